@@ rtl/binary_to_decimal_digits_unit_macros.svh @@
`ifndef BINARY_TO_DECIMAL_DIGITS_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_UNIT_MACROS_SVH

// same-cycle implication
`define B2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/b2d_pkg.sv @@
package b2d_pkg;

  localparam int VALUE_W        = 32;
  localparam int DIGIT_W        = 4;
  localparam int MAX_DIGITS_DEF = 10;

endpackage

@@ rtl/binary_to_decimal_digits_unit.sv @@
// Flow: the converter runs a shift-add-three step for each value bit, then
// hands the digits over to the shifter, which drops leading zeros before the
// first digit word is shown; the digit shifter overlaps the converter and
// holds a word while out_ready is low.
// A new value enters the converter while the previous one is still sent.
// Reset: synchronous, active high; clears all control state, no words held.
`include "binary_to_decimal_digits_unit_macros.svh"

module binary_to_decimal_digits_unit #(
  parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [b2d_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [b2d_pkg::DIGIT_W-1:0]   digit,
  output logic                          last
);
  import b2d_pkg::*;

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;

  logic             done;
  logic             take;
  logic [BCD_W-1:0] bcd;

  b2d_dabble #(.MAX_DIGITS(MAX_DIGITS)) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (in_valid),
    .value (value),
    .idle  (in_ready),
    .done  (done),
    .take  (take),
    .bcd   (bcd)
  );

  b2d_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .done      (done),
    .take      (take),
    .bcd       (bcd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digit     (digit),
    .last      (last)
  );

  `B2D_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready during conversion")
  `B2D_ASSERT_NOW(a_digit_decimal, out_valid, digit <= DIGIT_W'(9), "digit above nine")
  `B2D_ASSERT_NEXT(a_end_of_run, out_valid && out_ready && last, !out_valid, "word after last")

endmodule

@@ rtl/b2d_dabble.sv @@
module b2d_dabble #(
  parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic [b2d_pkg::VALUE_W-1:0]                 value,
  output logic                                        idle,
  output logic                                        done,
  input  logic                                        take,
  output logic [b2d_pkg::DIGIT_W*MAX_DIGITS-1:0]      bcd
);
  import b2d_pkg::*;

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;
  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] bin;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [BCD_W-1:0]   adj;
  logic [BCD_W-1:0]   bcd_next;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
    bcd_next = {adj[BCD_W-2:0], bin[VALUE_W-1]};
  end

  assign idle = !busy && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start && idle) begin
        bin  <= value;
        bcd  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        bcd <= bcd_next;
        bin <= {bin[VALUE_W-2:0], 1'b0};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (done && take) begin
        done <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/b2d_emit.sv @@
module b2d_emit #(
  parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        done,
  output logic                                        take,
  input  logic [b2d_pkg::DIGIT_W*MAX_DIGITS-1:0]      bcd,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [b2d_pkg::DIGIT_W-1:0]                 digit,
  output logic                                        last
);
  import b2d_pkg::*;

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;
  localparam int REM_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {IDLE, SKIP, SEND} state_t;

  state_t           state;
  logic [BCD_W-1:0] digits;
  logic [REM_W-1:0] remain;
  logic [DIGIT_W-1:0] top;

  assign top       = digits[BCD_W-1 -: DIGIT_W];
  assign take      = done && (state == IDLE);
  assign out_valid = (state == SEND);
  assign digit     = top;
  assign last      = (remain == REM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      remain <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (done) begin
            digits <= bcd;
            remain <= REM_W'(MAX_DIGITS);
            state  <= SKIP;
          end
        end
        SKIP: begin
          if (top != '0) begin
            state <= SEND;
          end else if (remain == REM_W'(1)) begin
            state <= IDLE;
          end else begin
            digits <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            remain <= remain - REM_W'(1);
          end
        end
        SEND: begin
          if (out_ready) begin
            if (remain == REM_W'(1)) begin
              state <= IDLE;
            end else begin
              digits <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
              remain <= remain - REM_W'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
